// ===== rtl/differential_thruster_mixer_macros.svh =====
// Assertion macros for the differential thruster mixer.
`ifndef DIFFERENTIAL_THRUSTER_MIXER_MACROS_SVH
`define DIFFERENTIAL_THRUSTER_MIXER_MACROS_SVH

`ifndef SYNTHESIS

// Plain property checked on every rising clock edge out of reset.
`define DTM_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("dtm assertion failed");

// Condition in one cycle implies the result in the next.
`define DTM_ASSERT_NEXT(name, cond, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("dtm assertion failed");

`else

`define DTM_ASSERT(name, expr)
`define DTM_ASSERT_NEXT(name, cond, expr)

`endif

`endif

// ===== rtl/dtm_pkg.sv =====
// Types and constants for the differential thruster mixer.
package dtm_pkg;

	typedef enum logic [1:0] {
		CMD_AUTO   = 2'd0,
		CMD_MANUAL = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_ENABLE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_GAIN        = 3'd0,
		REG_MAX_LINEAR  = 3'd1,
		REG_MAX_ANGULAR = 3'd2,
		REG_STOP_DELAY  = 3'd3,
		REG_MAX_STEP    = 3'd4,
		REG_MODE_FLAGS  = 3'd5
	} reg_idx_t;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [7:0] PWM_STOP = 8'd150;
	localparam logic [7:0] PWM_MIN  = 8'd110;
	localparam logic [7:0] PWM_MAX  = 8'd190;

	localparam logic [15:0] GAIN_RST        = 16'd2304;
	localparam logic [14:0] MAX_LINEAR_RST  = 15'd256;
	localparam logic [14:0] MAX_ANGULAR_RST = 15'd256;
	localparam logic [15:0] STOP_DELAY_RST  = 16'd5;
	localparam logic [7:0]  MAX_STEP_RST    = 8'd1;
	localparam logic [2:0]  MODE_FLAGS_RST  = 3'd0;

	localparam int unsigned MODE_BACKWARD  = 0;
	localparam int unsigned MODE_INV_LEFT  = 1;
	localparam int unsigned MODE_INV_RIGHT = 2;

	localparam logic [15:0] AGE_TIMED_OUT = 16'hFFFF;

	typedef struct packed {
		cmd_t               cmd;
		logic signed [15:0] linear;
		logic signed [15:0] angular;
		logic               enable;
	} item_t;

	typedef struct packed {
		logic [7:0] pwm_left;
		logic [7:0] pwm_right;
		logic       from_enable;
	} result_t;

endpackage

// ===== rtl/differential_thruster_mixer.sv =====
// Differential thruster mixer: command store, mix, scale, clamp and slew limit.
//
//  channel  | handshake                  | beat
//  ---------+----------------------------+------------------------------------------
//  item     | item_valid / item_stall    | cmd, linear, angular, enable
//  result   | result_valid / result_stall| pwm_left, pwm_right, from_enable
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// An accepted beat lands in the input register; when it moves on, it is worked
// through the mix, the 17x16 gain multiply, rounding, clamp, mirror and slew,
// and its result (if any) is registered in the result register.
// Sustained rate is one item per cycle while the result side does not stall.
// A stalled result register holds the item in the input register, so the
// item side stalls only while a result waits and another item is queued.
// Reset clears command ages to timed out, sets enabled and both last PWM
// values to stop, and loads the configuration defaults; no clearing pass.
`include "differential_thruster_mixer_macros.svh"

module differential_thruster_mixer (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        item_valid,
	output logic                        item_stall,
	input  dtm_pkg::item_t              item,

	output logic                        result_valid,
	input  logic                        result_stall,
	output dtm_pkg::result_t            result,

	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dtm_pkg::ADDR_W-1:0]  paddr,
	input  logic [dtm_pkg::DATA_W-1:0]  pwdata,
	output logic [dtm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	import dtm_pkg::*;

	localparam logic signed [33:0] STOP_SCALED = 34'(PWM_STOP) <<< 16;
	localparam logic [8:0]         STOP_TWICE  = {PWM_STOP, 1'b0};

	// Q8.8 side velocity to PWM: scale, offset, round half away, clamp.
	function automatic logic [7:0] to_pwm(input logic signed [16:0] v,
			input logic [15:0] g);
		logic signed [33:0] s;
		logic [32:0]        rnd;
		logic [16:0]        r;
		logic [7:0]         res;
		s   = (34'(v) * 34'($signed({1'b0, g}))) + STOP_SCALED;
		rnd = s[32:0] + 33'd32768;
		r   = rnd[32:16];
		if (s[33]) begin
			// any negative sum rounds to zero or below
			res = PWM_MIN;
		end else if (r > 17'(PWM_MAX)) begin
			res = PWM_MAX;
		end else if (r < 17'(PWM_MIN)) begin
			res = PWM_MIN;
		end else begin
			res = r[7:0];
		end
		return res;
	endfunction

	function automatic logic signed [15:0] clamp_mag(input logic signed [15:0] v,
			input logic [14:0] lim);
		logic signed [16:0] lv;
		logic signed [16:0] vx;
		logic signed [15:0] res;
		lv = $signed({2'b00, lim});
		vx = {v[15], v};
		if (vx > lv) begin
			res = $signed({1'b0, lim});
		end else if (vx < -lv) begin
			res = -$signed({1'b0, lim});
		end else begin
			res = v;
		end
		return res;
	endfunction

	function automatic logic [7:0] slew(input logic [7:0] last, input logic [7:0] target,
			input logic [7:0] step);
		logic signed [9:0] st;
		logic signed [9:0] d;
		logic signed [9:0] sum;
		st = $signed({2'b00, (step == 8'd0) ? 8'd1 : step});
		d  = $signed({2'b00, target}) - $signed({2'b00, last});
		if (d > st) begin
			d = st;
		end else if (d < -st) begin
			d = -st;
		end
		sum = $signed({2'b00, last}) + d;
		return sum[7:0];
	endfunction

	function automatic logic [15:0] age_inc(input logic [15:0] age);
		return (age == AGE_TIMED_OUT) ? age : age + 16'd1;
	endfunction

	// configuration registers
	logic [15:0] gain_q;
	logic [14:0] max_linear_q;
	logic [14:0] max_angular_q;
	logic [15:0] stop_delay_q;
	logic [7:0]  max_step_q;
	logic [2:0]  mode_flags_q;

	// block state
	logic signed [15:0] auto_linear_q, auto_angular_q;
	logic signed [15:0] manual_linear_q, manual_angular_q;
	logic [15:0]        auto_age_q, manual_age_q;
	logic               enabled_q, stop_done_q;
	logic [7:0]         last_left_q, last_right_q;

	// next state
	logic signed [15:0] auto_linear_n, auto_angular_n;
	logic signed [15:0] manual_linear_n, manual_angular_n;
	logic [15:0]        auto_age_n, manual_age_n;
	logic               enabled_n, stop_done_n;
	logic [7:0]         last_left_n, last_right_n;

	// pipeline
	logic    valid_s1;
	item_t   item_s1;
	logic    adv;
	logic    produce;
	result_t res_n;
	logic    res_valid_q;
	result_t res_q;

	// tick datapath
	logic               man_fresh, auto_fresh;
	logic signed [15:0] auto_lin_c, auto_ang_c;
	logic signed [15:0] l, a;
	logic signed [16:0] left, right;
	logic [7:0]         tl, tr, ml, mr;
	logic [8:0]         mirror_l, mirror_r;
	logic               is_stop;

	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	// ---------------------------------------------------------------- config
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= GAIN_RST;
			max_linear_q  <= MAX_LINEAR_RST;
			max_angular_q <= MAX_ANGULAR_RST;
			stop_delay_q  <= STOP_DELAY_RST;
			max_step_q    <= MAX_STEP_RST;
			mode_flags_q  <= MODE_FLAGS_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_GAIN:        gain_q        <= pwdata[15:0];
				REG_MAX_LINEAR:  max_linear_q  <= pwdata[14:0];
				REG_MAX_ANGULAR: max_angular_q <= pwdata[14:0];
				REG_STOP_DELAY:  stop_delay_q  <= pwdata[15:0];
				REG_MAX_STEP:    max_step_q    <= pwdata[7:0];
				REG_MODE_FLAGS:  mode_flags_q  <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_GAIN:        prdata = DATA_W'(gain_q);
			REG_MAX_LINEAR:  prdata = DATA_W'(max_linear_q);
			REG_MAX_ANGULAR: prdata = DATA_W'(max_angular_q);
			REG_STOP_DELAY:  prdata = DATA_W'(stop_delay_q);
			REG_MAX_STEP:    prdata = DATA_W'(max_step_q);
			REG_MODE_FLAGS:  prdata = DATA_W'(mode_flags_q);
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------- handshake
	// The held item moves on when the result register is empty or being taken.
	assign adv          = valid_s1 && (!res_valid_q || !result_stall);
	assign item_stall   = valid_s1 && !adv;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// ------------------------------------------------------------ tick path
	always_comb begin
		man_fresh  = manual_age_q < stop_delay_q;
		auto_fresh = auto_age_q < stop_delay_q;
		auto_lin_c = clamp_mag(auto_linear_q, max_linear_q);
		auto_ang_c = clamp_mag(auto_angular_q, max_angular_q);
		l = man_fresh ? manual_linear_q : auto_lin_c;
		a = man_fresh ? manual_angular_q : auto_ang_c;
		left  = {l[15], l} + {a[15], a};
		right = {l[15], l} - {a[15], a};
		if (!mode_flags_q[MODE_BACKWARD]) begin
			if (left[16]) left = '0;
			if (right[16]) right = '0;
		end
		if (man_fresh || auto_fresh) begin
			tl = to_pwm(left, gain_q);
			tr = to_pwm(right, gain_q);
		end else begin
			tl = PWM_STOP;
			tr = PWM_STOP;
		end
		// stop test sees the unmirrored targets
		is_stop  = (tl == PWM_STOP) && (tr == PWM_STOP);
		mirror_l = STOP_TWICE - {1'b0, tl};
		mirror_r = STOP_TWICE - {1'b0, tr};
		ml = mode_flags_q[MODE_INV_LEFT]  ? mirror_l[7:0] : tl;
		mr = mode_flags_q[MODE_INV_RIGHT] ? mirror_r[7:0] : tr;
	end

	// ------------------------------------------------------------ state update
	always_comb begin
		auto_linear_n    = auto_linear_q;
		auto_angular_n   = auto_angular_q;
		manual_linear_n  = manual_linear_q;
		manual_angular_n = manual_angular_q;
		auto_age_n       = auto_age_q;
		manual_age_n     = manual_age_q;
		enabled_n        = enabled_q;
		stop_done_n      = stop_done_q;
		last_left_n      = last_left_q;
		last_right_n     = last_right_q;
		produce          = 1'b0;
		res_n            = '{pwm_left: PWM_STOP, pwm_right: PWM_STOP, from_enable: 1'b0};

		if (adv) begin
			case (item_s1.cmd)
				CMD_AUTO: begin
					auto_linear_n  = item_s1.linear;
					auto_angular_n = item_s1.angular;
					auto_age_n     = '0;
				end
				CMD_MANUAL: begin
					manual_linear_n  = item_s1.linear;
					manual_angular_n = item_s1.angular;
					manual_age_n     = '0;
				end
				CMD_ENABLE: begin
					enabled_n         = item_s1.enable;
					stop_done_n       = 1'b1;
					produce           = 1'b1;
					res_n.from_enable = 1'b1;
				end
				CMD_TICK: begin
					auto_age_n   = age_inc(auto_age_q);
					manual_age_n = age_inc(manual_age_q);
					if (enabled_q) begin
						// clamped automatic command is written back
						if (auto_fresh && !man_fresh) begin
							auto_linear_n  = auto_lin_c;
							auto_angular_n = auto_ang_c;
						end
						if (!is_stop || !stop_done_q) begin
							stop_done_n     = is_stop;
							produce         = 1'b1;
							last_left_n     = slew(last_left_q, ml, max_step_q);
							last_right_n    = slew(last_right_q, mr, max_step_q);
							res_n.pwm_left  = last_left_n;
							res_n.pwm_right = last_right_n;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_linear_q    <= '0;
			auto_angular_q   <= '0;
			manual_linear_q  <= '0;
			manual_angular_q <= '0;
			auto_age_q       <= AGE_TIMED_OUT;
			manual_age_q     <= AGE_TIMED_OUT;
			enabled_q        <= 1'b1;
			stop_done_q      <= 1'b0;
			last_left_q      <= PWM_STOP;
			last_right_q     <= PWM_STOP;
		end else begin
			auto_linear_q    <= auto_linear_n;
			auto_angular_q   <= auto_angular_n;
			manual_linear_q  <= manual_linear_n;
			manual_angular_q <= manual_angular_n;
			auto_age_q       <= auto_age_n;
			manual_age_q     <= manual_age_n;
			enabled_q        <= enabled_n;
			stop_done_q      <= stop_done_n;
			last_left_q      <= last_left_n;
			last_right_q     <= last_right_n;
		end
	end

	// ------------------------------------------------------------ result reg
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= produce;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			res_q <= res_n;
		end
	end

	// ------------------------------------------------------------ checks
	`DTM_ASSERT(a_stall_needs_item, !item_stall || (valid_s1 && res_valid_q))
	`DTM_ASSERT(a_enable_beat_is_stop, !(result_valid && result.from_enable) || (result.pwm_left == PWM_STOP && result.pwm_right == PWM_STOP))
	`DTM_ASSERT(a_tick_beat_tracks_last, !(result_valid && !result.from_enable) || (result.pwm_left == last_left_q && result.pwm_right == last_right_q))
	`DTM_ASSERT_NEXT(a_enable_sets_stop_done, adv && item_s1.cmd == CMD_ENABLE, stop_done_q)

endmodule

// ===== tb/sv/tb_differential_thruster_mixer.sv =====
// Testbench for the differential thruster mixer: directed and random beats, predictor checked.
module tb_differential_thruster_mixer;
	import dtm_pkg::*;

	// PWM constants as signed ints, so that the predictor's arithmetic never mixes
	// signed and unsigned operands.
	localparam int STOP_I = int'(PWM_STOP);
	localparam int MIN_I  = int'(PWM_MIN);
	localparam int MAX_I  = int'(PWM_MAX);

	// Extra cycles after the last expected result before any register write or the
	// end. A tick that gives no result can still be in the input or result stage.
	localparam int SETTLE_CYCLES = 4;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	item_t               item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	always #1 clk = ~clk;

	differential_thruster_mixer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// ------------------------------------------------------------------
	// Predictor state: a private copy of the registers and the mixer state.
	// ------------------------------------------------------------------
	logic [15:0]        m_gain       = GAIN_RST;
	logic [14:0]        m_max_lin    = MAX_LINEAR_RST;
	logic [14:0]        m_max_ang    = MAX_ANGULAR_RST;
	logic [15:0]        m_stop_delay = STOP_DELAY_RST;
	logic [7:0]         m_max_step   = MAX_STEP_RST;
	logic [2:0]         m_mode       = MODE_FLAGS_RST;

	logic signed [15:0] auto_lin = '0, auto_ang = '0;
	logic signed [15:0] man_lin = '0, man_ang = '0;
	logic [15:0]        auto_age = AGE_TIMED_OUT, man_age = AGE_TIMED_OUT;
	bit                 motors_on = 1'b1;
	bit                 stop_latched = 1'b0;
	logic [7:0]         last_l = PWM_STOP, last_r = PWM_STOP;

	result_t            pwm_expected[$];   // PWM writes still owed by the block, oldest first
	int                 errors = 0;

	// Idle and stall rates in percent per cycle; hold_left forces a long stall.
	int                 send_idle_pct = 0;
	int                 stall_pct = 0;
	int                 hold_left = 0;

	task automatic report_mismatch(string what, int unsigned want, int unsigned got);
		$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
		errors++;
	endtask

	function automatic int clamp_mag(int v, int lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Side velocity (Q8.8) times gain (Q8.8), plus stop, rounded half away from zero.
	function automatic int velocity_to_pwm(int v);
		longint s, r;
		s = longint'(v) * longint'(m_gain) + longint'(STOP_I) * 65536;
		if (s >= 0) r = (s + 32768) / 65536;
		else r = -((-s + 32768) / 65536);
		if (r > MAX_I) r = MAX_I;
		if (r < MIN_I) r = MIN_I;
		return int'(r);
	endfunction

	function automatic logic [7:0] slew_toward(logic [7:0] last, int target);
		int step, d;
		step = (m_max_step == 8'd0) ? 1 : int'(m_max_step);
		d = target - int'(last);
		if (d > step) d = step;
		if (d < -step) d = -step;
		return 8'(int'(last) + d);
	endfunction

	// Runs one accepted beat through the mixer and queues the PWM write it causes.
	task automatic predict_beat(input item_t it);
		bit      man_fresh, auto_fresh;
		int      l, a, lft, rgt, tl, tr;
		result_t r;
		case (it.cmd)
			CMD_AUTO: begin
				auto_lin = it.linear;
				auto_ang = it.angular;
				auto_age = '0;
			end
			CMD_MANUAL: begin
				man_lin = it.linear;
				man_ang = it.angular;
				man_age = '0;
			end
			CMD_ENABLE: begin
				// immediate stop; last PWM values stay as they were
				motors_on = it.enable;
				stop_latched = 1'b1;
				r.pwm_left = PWM_STOP;
				r.pwm_right = PWM_STOP;
				r.from_enable = 1'b1;
				pwm_expected.push_back(r);
			end
			default: begin
				man_fresh = man_age < m_stop_delay;
				auto_fresh = auto_age < m_stop_delay;
				if (man_age != AGE_TIMED_OUT) man_age++;
				if (auto_age != AGE_TIMED_OUT) auto_age++;
				if (!motors_on) return;
				if (man_fresh || auto_fresh) begin
					if (man_fresh) begin
						l = int'(man_lin);
						a = int'(man_ang);
					end else begin
						// automatic command is clamped and stored back clamped
						l = clamp_mag(int'(auto_lin), int'(m_max_lin));
						a = clamp_mag(int'(auto_ang), int'(m_max_ang));
						auto_lin = 16'(l);
						auto_ang = 16'(a);
					end
					lft = l + a;
					rgt = l - a;
					if (!m_mode[MODE_BACKWARD]) begin
						if (lft < 0) lft = 0;
						if (rgt < 0) rgt = 0;
					end
					tl = velocity_to_pwm(lft);
					tr = velocity_to_pwm(rgt);
				end else begin
					tl = STOP_I;
					tr = STOP_I;
				end
				// stop test on unmirrored targets; a repeated stop is dropped even mid-slew
				if (tl != STOP_I || tr != STOP_I) begin
					stop_latched = 1'b0;
				end else begin
					if (stop_latched) return;
					stop_latched = 1'b1;
				end
				if (m_mode[MODE_INV_LEFT]) tl = (2 * STOP_I - tl) & 255;
				if (m_mode[MODE_INV_RIGHT]) tr = (2 * STOP_I - tr) & 255;
				last_l = slew_toward(last_l, tl);
				last_r = slew_toward(last_r, tr);
				r.pwm_left = last_l;
				r.pwm_right = last_r;
				r.from_enable = 1'b0;
				pwm_expected.push_back(r);
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Monitor: sampled at the rising edge, before the block's flops update.
	// Results are checked in order; accepted beats feed the predictor. A beat's
	// result passes the input and result registers, so it never shows at the edge that accepts it.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pwm_expected.size() == 0) begin
					report_mismatch("result with nothing pending", 0, 32'(result));
				end else begin
					want = pwm_expected.pop_front();
					if (result.pwm_left !== want.pwm_left)
						report_mismatch("pwm_left", 32'(want.pwm_left),
							32'(result.pwm_left));
					if (result.pwm_right !== want.pwm_right)
						report_mismatch("pwm_right", 32'(want.pwm_right),
							32'(result.pwm_right));
					if (result.from_enable !== want.from_enable)
						report_mismatch("from_enable", 32'(want.from_enable),
							32'(result.from_enable));
				end
			end
			if (item_valid && !item_stall) predict_beat(item);
		end
	end

	// Receiver: a forced hold-off wins, otherwise stall at the phase's rate.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	function automatic item_t beat(cmd_t c, int lin, int ang, bit en);
		item_t it;
		it.cmd = c;
		it.linear = 16'(lin);
		it.angular = 16'(ang);
		it.enable = en;
		return it;
	endfunction

	// Offers one beat and returns at the edge it is taken. Valid stays high on
	// return, so back-to-back beats do not drop it.
	task automatic send_beat(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
	endtask

	// Sender pauses until every pending result is out, then the pipe drains.
	task automatic settle_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pwm_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] model_reg(reg_idx_t idx);
		case (idx)
			REG_GAIN:        return 32'(m_gain);
			REG_MAX_LINEAR:  return 32'(m_max_lin);
			REG_MAX_ANGULAR: return 32'(m_max_ang);
			REG_STOP_DELAY:  return 32'(m_stop_delay);
			REG_MAX_STEP:    return 32'(m_max_step);
			REG_MODE_FLAGS:  return 32'(m_mode);
			default:         return '0;
		endcase
	endfunction

	// Read over the config port; prdata is taken in the access cycle.
	task automatic reg_check(input reg_idx_t idx);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'(4 * int'(idx));
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== model_reg(idx))
			report_mismatch("register readback", model_reg(idx), prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Setup then access cycle; the model follows once the write has landed.
	task automatic set_register(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * int'(idx));
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GAIN:        m_gain = val[15:0];
			REG_MAX_LINEAR:  m_max_lin = val[14:0];
			REG_MAX_ANGULAR: m_max_ang = val[14:0];
			REG_STOP_DELAY:  m_stop_delay = val[15:0];
			REG_MAX_STEP:    m_max_step = val[7:0];
			REG_MODE_FLAGS:  m_mode = val[2:0];
			default: ;
		endcase
		reg_check(idx);
	endtask

	task automatic load_setup(int gain, int max_lin, int max_ang, int delay, int step, int mode);
		set_register(REG_GAIN, gain);
		set_register(REG_MAX_LINEAR, max_lin);
		set_register(REG_MAX_ANGULAR, max_ang);
		set_register(REG_STOP_DELAY, delay);
		set_register(REG_MAX_STEP, step);
		set_register(REG_MODE_FLAGS, mode);
	endtask

	// Mostly velocity commands and ticks; small velocities keep the PWM off the
	// rails, full 16-bit values hit the clamps and every bit.
	function automatic item_t random_beat();
		int    pick;
		item_t it;
		pick = $urandom_range(99);
		it.linear = 16'($urandom);
		it.angular = 16'($urandom);
		it.enable = ($urandom_range(9) != 0);
		if (pick < 25) it.cmd = CMD_AUTO;
		else if (pick < 40) it.cmd = CMD_MANUAL;
		else if (pick < 92) it.cmd = CMD_TICK;
		else it.cmd = CMD_ENABLE;
		if ((it.cmd == CMD_AUTO || it.cmd == CMD_MANUAL) && $urandom_range(3) != 0) begin
			it.linear = 16'(int'($urandom_range(1024)) - 512);
			it.angular = 16'(int'($urandom_range(1024)) - 512);
		end
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_reset_values();
		for (int i = 0; i <= int'(REG_MODE_FLAGS); i++) reg_check(reg_idx_t'(i));
	endtask

	task automatic test_directed_mixing();
		// reset setup: gain 9.0, clamps 1.0, fresh for 5 ticks, step 1, forward only
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));              // nothing fresh: one stop
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));              // repeated stop dropped
		send_beat(beat(CMD_AUTO, 32767, -32768, 1'b0));     // clamped on the tick
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));
		send_beat(beat(CMD_MANUAL, -32768, 32767, 1'b1));   // manual wins, negative sides to zero
		send_beat(beat(CMD_TICK, -1, -1, 1'b1));
		send_beat(beat(CMD_ENABLE, 0, 0, 1'b0));            // disable: stop from enable
		send_beat(beat(CMD_TICK, 0, 0, 1'b1));              // disabled tick, ages only
		send_beat(beat(CMD_ENABLE, -1, -1, 1'b1));
		settle_results();

		// high extremes: backward allowed, both sides mirrored, full step
		load_setup(65535, 32767, 0, 1, 255, 7);
		send_beat(beat(CMD_MANUAL, 32767, 32767, 1'b0));
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));              // one-tick freshness: stale, stop
		send_beat(beat(CMD_AUTO, -32768, 32767, 1'b0));
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));
		settle_results();

		// zero gain: every target is stop, so suppression decides
		load_setup(0, 0, 0, 3, 2, 1);
		send_beat(beat(CMD_MANUAL, -1, 1, 1'b0));
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));
		send_beat(beat(CMD_ENABLE, 0, 0, 1'b1));
		send_beat(beat(CMD_AUTO, 100, -100, 1'b0));
		send_beat(beat(CMD_TICK, 0, 0, 1'b0));
		settle_results();
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: load_setup(0, 0, 0, 1, 1, 0);
				1: load_setup(65535, 32767, 32767, 65535, 255, 7);
				default: load_setup(
					($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(256, 8192),
					($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1024),
					($urandom_range(3) == 0) ? $urandom_range(32767) : $urandom_range(1024),
					($urandom_range(7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 8),
					($urandom_range(3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8),
					$urandom_range(7));
			endcase
			// idling pattern rotates: none, sender gaps, receiver stalls, both
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 55; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 55; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			repeat (100) send_beat(random_beat());
			settle_results();
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	// Long receiver hold-off with the sender streaming: a result waits in the
	// result register and the item side has to stall.
	task automatic test_backpressure();
		load_setup(int'(GAIN_RST), int'(MAX_LINEAR_RST), int'(MAX_ANGULAR_RST), 4, 3, 2);
		hold_left = 80;
		for (int i = 0; i < 40; i++) begin
			if (i % 4 == 0) send_beat(beat(CMD_MANUAL, int'($urandom_range(600)) - 300,
				int'($urandom_range(600)) - 300, 1'b1));
			else send_beat(beat(CMD_TICK, 0, 0, 1'b1));
		end
		settle_results();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed_mixing();
		test_random_phases();
		test_backpressure();
		settle_results();
		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
